// ===== hw/rtl/assert_macros.svh =====
// Concurrent assertion helpers for the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked during reset as well.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hw/rtl/tun_pkg.sv =====
`default_nettype none
package tun_pkg;
   localparam int COORD_WIDTH_DEF      = 16;
   localparam int NORMAL_FRAC_BITS_DEF = 15;
   // normalized magnitude width, the largest one lies in [2^30, 2^31)
   localparam int SCALE_BITS = 31;
   localparam int SUM_BITS   = 2 * SCALE_BITS + 2;
   localparam int ROOT_BITS  = SUM_BITS / 2;

   // data carried alongside the length computation
   typedef struct packed {
      logic [2:0]                  neg;
      logic                        degen;
      logic [2:0][SCALE_BITS-1:0]  s;
   } side_type;
endpackage
`default_nettype wire

// ===== hw/rtl/triangle_unit_normal.sv =====
// Unit face normal of a triangle.
// req channel: one transaction carries three corners, nine signed coords of
//   COORD_WIDTH bits each. rsp channel: one transaction per request with the
//   unit normal in signed Q1.NORMAL_FRAC_BITS and a degenerate flag in tuser.
// Pipeline: 8 stages for edges, cross product, scaling and the sum of
//   squares, 32 stages of the one-bit-per-stage square root, one setup
//   stage and NORMAL_FRAC_BITS + 1 stages of the restoring divider (three
//   dividers side by side), and the output register.
// Throughput: one triangle per cycle while the pipeline is not stalled.
// Stall: all stages share one enable; while the response is held and
//   rsp_tready is low the whole pipeline freezes and req_tready drops.
//   Nothing is lost or repeated.
// Reset clears all valid bits; the pipeline then comes up empty.
// A zero cross product gives zero components and tuser set. A component
//   of +1.0 saturates to the largest positive code.
`default_nettype none
module triangle_unit_normal #(
   parameter int COORD_WIDTH      = tun_pkg::COORD_WIDTH_DEF,
   parameter int NORMAL_FRAC_BITS = tun_pkg::NORMAL_FRAC_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic      req_tready,
   // first_x, first_y, first_z, second_x .. third_z, then zero padding
   input  wire logic [((9*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   // normal_x, normal_y, normal_z, then zero padding
   output logic [((3*(NORMAL_FRAC_BITS+1)+7)/8)*8-1:0] rsp_tdata,
   // degenerate
   output logic [0:0] rsp_tuser
);
   import tun_pkg::*;

   localparam int CW   = COORD_WIDTH;
   localparam int NF   = NORMAL_FRAC_BITS;
   localparam int OW   = NF + 1;
   localparam int EW   = CW + 1;
   localparam int PW   = 2 * EW;
   localparam int CRW  = 2 * CW + 3;
   localparam int BLW  = $clog2(CRW + 1);
   localparam int NW   = SCALE_BITS + NF + 1;
   localparam int RW   = ROOT_BITS + 1;
   localparam int SQS  = ROOT_BITS;
   localparam int DVS  = OW;
   localparam int ODW  = ((3*OW+7)/8)*8;

   logic en;
   assign en = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   // stage 1: edges
   logic               v1_ff;
   logic signed [EW-1:0] e_ff [3];
   logic signed [EW-1:0] f_ff [3];
   // stage 2: products
   logic               v2_ff;
   logic signed [PW-1:0] p_ff [6];
   // stage 3: cross product
   logic               v3_ff;
   logic signed [CRW-1:0] c_ff [3];
   // stage 4: magnitudes
   logic               v4_ff;
   logic [CRW-1:0]     m4_ff [3];
   logic [2:0]         n4_ff;
   logic               d4_ff;
   // stage 5: bit length
   logic               v5_ff;
   logic [CRW-1:0]     m5_ff [3];
   logic [2:0]         n5_ff;
   logic               d5_ff;
   logic [BLW-1:0]     bl_ff;
   // stage 6: scaled magnitudes
   logic               v6_ff;
   side_type           sd6_ff;
   // stage 7: squares
   logic               v7_ff;
   side_type           sd7_ff;
   logic [2*SCALE_BITS-1:0] sq_ff [3];
   // stage 8: sum
   logic               v8_ff;
   side_type           sd8_ff;
   logic [SUM_BITS-1:0] sum_ff;
   // square root stages
   logic               sv_ff   [SQS];
   side_type           ssd_ff  [SQS];
   logic [SUM_BITS-1:0] sval_ff [SQS];
   logic [RW:0]        srem_ff [SQS];
   logic [ROOT_BITS-1:0] sroot_ff [SQS];
   // divider setup
   logic               dv0_ff;
   logic [2:0]         dn0_ff;
   logic               dd0_ff;
   logic [ROOT_BITS-1:0] dl0_ff;
   logic [RW-1:0]      dr0_ff [3];
   logic [NF:0]        db0_ff [3];
   // divider stages
   logic               dv_ff [DVS];
   logic [2:0]         dn_ff [DVS];
   logic               dd_ff [DVS];
   logic [ROOT_BITS-1:0] dl_ff [DVS];
   logic [RW-1:0]      dr_ff [DVS][3];
   logic [NF:0]        db_ff [DVS][3];
   logic [OW-1:0]      dq_ff [DVS][3];
   // output
   logic               ov_ff;
   logic [OW-1:0]      on_ff [3];
   logic               od_ff;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; v4_ff <= 1'b0;
         v5_ff <= 1'b0; v6_ff <= 1'b0; v7_ff <= 1'b0; v8_ff <= 1'b0;
         dv0_ff <= 1'b0;
         ov_ff <= 1'b0;
         for (int k = 0; k < SQS; k++) sv_ff[k] <= 1'b0;
         for (int k = 0; k < DVS; k++) dv_ff[k] <= 1'b0;
      end else if (en) begin
         v1_ff <= req_tvalid; v2_ff <= v1_ff; v3_ff <= v2_ff; v4_ff <= v3_ff;
         v5_ff <= v4_ff; v6_ff <= v5_ff; v7_ff <= v6_ff; v8_ff <= v7_ff;
         sv_ff[0] <= v8_ff;
         for (int k = 1; k < SQS; k++) sv_ff[k] <= sv_ff[k-1];
         dv0_ff <= sv_ff[SQS-1];
         dv_ff[0] <= dv0_ff;
         for (int k = 1; k < DVS; k++) dv_ff[k] <= dv_ff[k-1];
         ov_ff <= dv_ff[DVS-1];
      end
   end

   // stages 1 to 3: edges, products, cross product
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            e_ff[i] <= EW'($signed(req_tdata[(3+i)*CW +: CW]))
                     - EW'($signed(req_tdata[i*CW +: CW]));
            f_ff[i] <= EW'($signed(req_tdata[(6+i)*CW +: CW]))
                     - EW'($signed(req_tdata[i*CW +: CW]));
         end
         p_ff[0] <= PW'(e_ff[1]) * PW'(f_ff[2]);
         p_ff[1] <= PW'(e_ff[2]) * PW'(f_ff[1]);
         p_ff[2] <= PW'(e_ff[2]) * PW'(f_ff[0]);
         p_ff[3] <= PW'(e_ff[0]) * PW'(f_ff[2]);
         p_ff[4] <= PW'(e_ff[0]) * PW'(f_ff[1]);
         p_ff[5] <= PW'(e_ff[1]) * PW'(f_ff[0]);
         for (int i = 0; i < 3; i++)
            c_ff[i] <= CRW'(p_ff[2*i]) - CRW'(p_ff[2*i+1]);
      end
   end

   // stages 4 to 6: sign and magnitude, bit length, common scaling
   logic [BLW-1:0] bl_in;
   logic [CRW-1:0] any_m;
   always_comb begin
      any_m = m4_ff[0] | m4_ff[1] | m4_ff[2];
      bl_in = '0;
      for (int b = 0; b < CRW; b++)
         if (any_m[b]) bl_in = BLW'(b + 1);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            n4_ff[i] <= c_ff[i][CRW-1];
            m4_ff[i] <= c_ff[i][CRW-1] ? CRW'(-c_ff[i]) : CRW'(c_ff[i]);
         end
         d4_ff <= (c_ff[0] == '0) && (c_ff[1] == '0) && (c_ff[2] == '0);
         m5_ff <= m4_ff;
         n5_ff <= n4_ff;
         d5_ff <= d4_ff;
         bl_ff <= bl_in;
         sd6_ff.neg   <= n5_ff;
         sd6_ff.degen <= d5_ff;
         for (int i = 0; i < 3; i++)
            sd6_ff.s[i] <= SCALE_BITS'({m5_ff[i], {SCALE_BITS{1'b0}}} >> bl_ff);
      end
   end

   // stages 7 and 8: squares and their sum
   always_ff @(posedge clock) begin
      if (en) begin
         sd7_ff <= sd6_ff;
         for (int i = 0; i < 3; i++)
            sq_ff[i] <= (2*SCALE_BITS)'(sd6_ff.s[i]) * (2*SCALE_BITS)'(sd6_ff.s[i]);
         sd8_ff <= sd7_ff;
         sum_ff <= SUM_BITS'(sq_ff[0]) + SUM_BITS'(sq_ff[1]) + SUM_BITS'(sq_ff[2]);
      end
   end

   // square root, one result bit per stage
   logic [RW:0]          st_rem  [SQS];
   logic [RW:0]          st_trial[SQS];
   logic [RW:0]          prev_rem [SQS];
   logic [ROOT_BITS-1:0] prev_root[SQS];
   logic [SUM_BITS-1:0]  prev_val [SQS];
   always_comb begin
      for (int k = 0; k < SQS; k++) begin
         if (k == 0) begin
            prev_rem[k]  = '0;
            prev_root[k] = '0;
            prev_val[k]  = sum_ff;
         end else begin
            prev_rem[k]  = srem_ff[k-1];
            prev_root[k] = sroot_ff[k-1];
            prev_val[k]  = sval_ff[k-1];
         end
         st_rem[k]   = {prev_rem[k][RW-2:0], prev_val[k][SUM_BITS-1 -: 2]};
         st_trial[k] = {prev_root[k], 2'b01};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < SQS; k++) begin
            ssd_ff[k]  <= (k == 0) ? sd8_ff : ssd_ff[k-1];
            sval_ff[k] <= {prev_val[k][SUM_BITS-3:0], 2'b00};
            if (st_rem[k] >= st_trial[k]) begin
               srem_ff[k]  <= st_rem[k] - st_trial[k];
               sroot_ff[k] <= {prev_root[k][ROOT_BITS-2:0], 1'b1};
            end else begin
               srem_ff[k]  <= st_rem[k];
               sroot_ff[k] <= {prev_root[k][ROOT_BITS-2:0], 1'b0};
            end
         end
      end
   end

   // divider setup: numerator = s * 2^NF + len / 2
   logic [NW-1:0] num_in [3];
   always_comb begin
      for (int i = 0; i < 3; i++)
         num_in[i] = {ssd_ff[SQS-1].s[i], {NF{1'b0}}}
                   + NW'(sroot_ff[SQS-1] >> 1);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dn0_ff <= ssd_ff[SQS-1].neg;
         dd0_ff <= ssd_ff[SQS-1].degen;
         dl0_ff <= sroot_ff[SQS-1];
         for (int i = 0; i < 3; i++) begin
            dr0_ff[i] <= RW'(num_in[i][NW-1:NF+1]);
            db0_ff[i] <= num_in[i][NF:0];
         end
      end
   end

   // restoring division, one quotient bit per stage
   logic [RW-1:0]        dt_rem [DVS][3];
   logic [RW-1:0]        dp_rem [DVS][3];
   logic [NF:0]          dp_bit [DVS][3];
   logic [OW-1:0]        dp_q   [DVS][3];
   logic [ROOT_BITS-1:0] dp_len [DVS];
   always_comb begin
      for (int k = 0; k < DVS; k++) begin
         dp_len[k] = (k == 0) ? dl0_ff : dl_ff[k-1];
         for (int i = 0; i < 3; i++) begin
            if (k == 0) begin
               dp_rem[k][i] = dr0_ff[i];
               dp_bit[k][i] = db0_ff[i];
               dp_q[k][i]   = '0;
            end else begin
               dp_rem[k][i] = dr_ff[k-1][i];
               dp_bit[k][i] = db_ff[k-1][i];
               dp_q[k][i]   = dq_ff[k-1][i];
            end
            dt_rem[k][i] = {dp_rem[k][i][RW-2:0], dp_bit[k][i][NF]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < DVS; k++) begin
            dn_ff[k] <= (k == 0) ? dn0_ff : dn_ff[k-1];
            dd_ff[k] <= (k == 0) ? dd0_ff : dd_ff[k-1];
            dl_ff[k] <= dp_len[k];
            for (int i = 0; i < 3; i++) begin
               db_ff[k][i] <= {dp_bit[k][i][NF-1:0], 1'b0};
               if (dt_rem[k][i] >= RW'(dp_len[k])) begin
                  dr_ff[k][i] <= dt_rem[k][i] - RW'(dp_len[k]);
                  dq_ff[k][i] <= {dp_q[k][i][OW-2:0], 1'b1};
               end else begin
                  dr_ff[k][i] <= dt_rem[k][i];
                  dq_ff[k][i] <= {dp_q[k][i][OW-2:0], 1'b0};
               end
            end
         end
      end
   end

   // output: sign, saturation of +1.0, degenerate case
   localparam logic [OW-1:0] ONE = OW'(1) << NF;
   logic [OW-1:0] on_in [3];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (dd_ff[DVS-1])
            on_in[i] = '0;
         else if (dn_ff[DVS-1][i])
            on_in[i] = -dq_ff[DVS-1][i];
         else if (dq_ff[DVS-1][i] == ONE)
            on_in[i] = ONE - OW'(1);
         else
            on_in[i] = dq_ff[DVS-1][i];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         on_ff <= on_in;
         od_ff <= dd_ff[DVS-1];
      end
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = ODW'({on_ff[2], on_ff[1], on_ff[0]});
   assign rsp_tuser  = od_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/tun_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module tun_checker #(
   parameter int NORMAL_FRAC_BITS = 15
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tready,
   input wire logic rsp_tvalid,
   input wire logic rsp_tready,
   input wire logic [((3*(NORMAL_FRAC_BITS+1)+7)/8)*8-1:0] rsp_tdata,
   input wire logic [0:0] rsp_tuser
);
   // pipeline comes out of reset empty
   `ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_tvalid)
   // a held response stays presented
   `ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   // a degenerate triangle gives all-zero components
   `ASSERT_IMPL(a_degen_zero, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tdata == '0)
   // the pipeline moves whenever the response side is free
   `ASSERT_IMPL(a_ready, clock, reset, !rsp_tvalid || rsp_tready, req_tready)
endmodule

bind triangle_unit_normal tun_checker #(
   .NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)
) u_tun_checker (.*);
`default_nettype wire
